/* rtl/spst_pkg.sv */
// Package for the sorted position set: command and status codes, widths.
// Used by the top module sorted_position_set_toggle; spst_ram does not import it.
package spst_pkg;

  localparam int PosW = 32;

  typedef enum logic [1:0] {
    CMD_TOGGLE = 2'd0,
    CMD_APPEND = 2'd1,
    CMD_RANGE  = 2'd2,
    CMD_CLEAR  = 2'd3
  } cmd_t;

  typedef enum logic [2:0] {
    ST_INSERTED  = 3'd0,
    ST_REMOVED   = 3'd1,
    ST_UNCHANGED = 3'd2,
    ST_FULL      = 3'd3,
    ST_ORDER     = 3'd4,
    ST_LISTED    = 3'd5,
    ST_NONE      = 3'd6,
    ST_CLEARED   = 3'd7
  } status_t;

  localparam logic [1:0] MODE_REMOVE_ONLY = 2'd0;
  localparam logic [1:0] MODE_INSERT_ONLY = 2'd1;
  localparam logic [1:0] MODE_BOTH        = 2'd2;

endpackage

/* rtl/spst_ram.sv */
// Generic single-port-write, single-read RAM with registered read data.
// No dependencies.
module spst_ram #(
  parameter int Width = 32,
  parameter int Depth = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(Depth)-1:0] waddr,
  input  logic [Width-1:0]         wdata,
  input  logic [$clog2(Depth)-1:0] raddr,
  output logic [Width-1:0]         rdata
);
  logic [Width-1:0] mem [Depth];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule

/* rtl/sorted_position_set_toggle.sv */
// Sorted position set: a strictly ascending set of 32-bit positions kept in one RAM.
// Requests toggle, append, list a range or clear the set. Uses spst_pkg and spst_ram.
//
// Usage: a request (command, position, range_end) enters on in_valid/in_ready.
// Results leave on out_valid/out_ready, one per request except range query,
// which lists every stored position in [position, range_end) with out_last
// on the final one. The sequencer works on one request at a time; in_ready is
// high only while it is idle. The output register parts the two sides, so the
// next request can enter and run while the last result still waits.
// Steps from accept to result: a toggle reads and compares each searched entry,
// decides, reads and writes each shifted entry, then emits; append reads the
// last entry, then checks and writes; clear emits at once; a range query searches,
// then reads and tests each entry up to the range end. The single RAM read port
// sets this pace. The next request is taken the cycle after the sequencer goes idle.
// A stalled receiver holds the output register; the sequencer then waits at
// its next result and in_ready stays low until that result is loaded.
// Reset empties the set (count to zero, no clearing pass), direction_mode = 2;
// cfg_we writes it, unchecked: write while idle to take effect on the next request.
module sorted_position_set_toggle #(
  parameter int CAPACITY = 64
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_we,
  input  logic [1:0]  cfg_direction_mode,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [1:0]  in_command,
  input  logic [31:0] in_position,
  input  logic [31:0] in_range_end,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [31:0] out_value,
  output logic        out_last,
  output logic [2:0]  out_status,
  output logic [6:0]  out_count
);
  import spst_pkg::*;

  localparam int AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int CW = $clog2(CAPACITY + 1);

  typedef enum logic [3:0] {
    S_IDLE, S_SRCH, S_SRCH_W, S_DECIDE, S_SHIFT_R, S_SHIFT_W,
    S_APP_R, S_APP_W, S_LIST_R, S_LIST_W, S_EMIT
  } state_t;

  state_t          state_r;
  logic [1:0]      mode_r;
  logic [CW-1:0]   occ_r;
  logic [1:0]      cmd_r;
  logic [31:0]     pos_r, end_r;
  logic [CW-1:0]   idx_r;     // search / shift / list index
  logic [CW-1:0]   stop_r;
  logic            ins_r;     // shift direction: 1 = insert (move up)
  logic [31:0]     carry_r;   // value carried while shifting up
  logic            first_r;   // range listing: no value held yet
  logic [31:0]     hold_r;    // previous listed value waiting for its last bit
  status_t         st_r;      // status of the request in progress

  logic            ov_r, ol_r;
  logic [31:0]     oval_r;
  logic [2:0]      ost_r;
  logic [CW-1:0]   ocnt_r;

  logic            we;
  logic [AW-1:0]   waddr, raddr;
  logic [31:0]     wdata, rdata;

  spst_ram #(.Width(32), .Depth(CAPACITY)) u_ram (
    .clk(clk), .we(we), .waddr(waddr), .wdata(wdata), .raddr(raddr), .rdata(rdata)
  );

  logic out_free;
  logic out_load;
  assign out_free  = !ov_r || out_ready;
  assign in_ready  = (state_r == S_IDLE);
  assign out_valid = ov_r;
  assign out_value = oval_r;
  assign out_last  = ol_r;
  assign out_status = ost_r;
  assign out_count = 7'(ocnt_r);

  always_comb begin
    we = 1'b0;
    waddr = idx_r[AW-1:0];
    wdata = carry_r;
    raddr = idx_r[AW-1:0];
    case (state_r)
      S_SHIFT_W: begin
        we = 1'b1;
        if (ins_r) begin
          wdata = carry_r;
        end else begin
          waddr = AW'(idx_r - CW'(1));
          wdata = rdata;
        end
      end
      S_APP_W: begin
        we = (occ_r == '0) || (rdata < pos_r);
        we = we && (occ_r < CW'(CAPACITY));
        waddr = occ_r[AW-1:0];
        wdata = pos_r;
      end
      default: ;
    endcase
  end

  // Cycles in which the output register takes a new result
  always_comb begin
    out_load = 1'b0;
    case (state_r)
      S_LIST_R: out_load = out_free && (idx_r >= occ_r);
      S_LIST_W: out_load = (rdata >= end_r) || !first_r;
      S_EMIT:   out_load = out_free;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      mode_r  <= MODE_BOTH;
      occ_r   <= '0;
      ov_r    <= 1'b0;
    end else begin
      if (cfg_we) mode_r <= cfg_direction_mode;
      if (out_load) ov_r <= 1'b1;
      else if (out_ready) ov_r <= 1'b0;
      case (state_r)
        S_IDLE: begin
          if (in_valid && in_ready) begin
            cmd_r <= in_command;
            pos_r <= in_position;
            end_r <= in_range_end;
            idx_r <= (cmd_t'(in_command) == CMD_APPEND) ? occ_r - CW'(1) : '0;
            first_r <= 1'b1;
            case (cmd_t'(in_command))
              CMD_CLEAR: begin
                occ_r <= '0;
                st_r <= ST_CLEARED;
                state_r <= S_EMIT;
              end
              CMD_APPEND: begin
                state_r <= S_APP_R;
              end
              CMD_RANGE: begin
                if (in_position >= in_range_end) begin
                  st_r <= ST_NONE;
                  state_r <= S_EMIT;
                end else begin
                  state_r <= S_SRCH;
                end
              end
              default: state_r <= S_SRCH;
            endcase
          end
        end
        // Linear lower-bound search: read idx, compare next cycle.
        S_SRCH: begin
          if (idx_r >= occ_r) state_r <= S_DECIDE;
          else state_r <= S_SRCH_W;
        end
        S_SRCH_W: begin
          if (rdata < pos_r) begin
            idx_r <= idx_r + CW'(1);
            state_r <= S_SRCH;
          end else if (cmd_r == CMD_RANGE) begin
            state_r <= S_LIST_R;
          end else begin
            state_r <= S_DECIDE;
          end
        end
        S_DECIDE: begin
          if (cmd_r == CMD_RANGE) begin
            state_r <= S_LIST_R;
          end else if (idx_r < occ_r && rdata == pos_r) begin
            if (mode_r == MODE_INSERT_ONLY) begin
              st_r <= ST_UNCHANGED; state_r <= S_EMIT;
            end else begin
              ins_r <= 1'b0;
              idx_r <= idx_r + CW'(1);
              stop_r <= occ_r;
              state_r <= S_SHIFT_R;
            end
          end else if (mode_r == MODE_REMOVE_ONLY) begin
            st_r <= ST_UNCHANGED; state_r <= S_EMIT;
          end else if (occ_r >= CW'(CAPACITY)) begin
            st_r <= ST_FULL; state_r <= S_EMIT;
          end else begin
            ins_r <= 1'b1;
            carry_r <= pos_r;
            stop_r <= occ_r;
            state_r <= S_SHIFT_R;
          end
        end
        // Insert: write carry at idx, carry old entry upward.
        // Remove: read idx, write it to idx-1.
        S_SHIFT_R: begin
          if (ins_r) begin
            if (idx_r == stop_r) begin
              state_r <= S_SHIFT_W;
              stop_r <= '0; // cleared; the final write is found by idx == occ
            end else begin
              state_r <= S_SHIFT_W;
            end
          end else if (idx_r >= stop_r) begin
            occ_r <= occ_r - CW'(1);
            st_r <= ST_REMOVED;
            state_r <= S_EMIT;
          end else begin
            state_r <= S_SHIFT_W;
          end
        end
        S_SHIFT_W: begin
          if (ins_r) begin
            carry_r <= rdata;
            if (idx_r == occ_r) begin
              occ_r <= occ_r + CW'(1);
              st_r <= ST_INSERTED;
              state_r <= S_EMIT;
            end else begin
              idx_r <= idx_r + CW'(1);
              state_r <= S_SHIFT_R;
            end
          end else begin
            idx_r <= idx_r + CW'(1);
            state_r <= S_SHIFT_R;
          end
        end
        S_APP_R: state_r <= S_APP_W;
        S_APP_W: begin
          if (occ_r != '0 && rdata >= pos_r) st_r <= ST_ORDER;
          else if (occ_r >= CW'(CAPACITY)) st_r <= ST_FULL;
          else begin
            st_r <= ST_INSERTED;
            occ_r <= occ_r + CW'(1);
          end
          state_r <= S_EMIT;
        end
        // Listing: read idx, next cycle test against end; each result is
        // held one step so its last bit is known. Wait here until the
        // output register is free.
        S_LIST_R: begin
          if (!out_free) begin
            state_r <= S_LIST_R;
          end else if (idx_r >= occ_r) begin
            ocnt_r <= occ_r;
            oval_r <= first_r ? pos_r : hold_r; ol_r <= 1'b1;
            ost_r <= first_r ? ST_NONE : ST_LISTED;
            state_r <= S_IDLE;
          end else begin
            state_r <= S_LIST_W;
          end
        end
        S_LIST_W: begin
          if (rdata >= end_r) begin
            ocnt_r <= occ_r;
            oval_r <= first_r ? pos_r : hold_r; ol_r <= 1'b1;
            ost_r <= first_r ? ST_NONE : ST_LISTED;
            state_r <= S_IDLE;
          end else begin
            if (!first_r) begin
              ocnt_r <= occ_r;
              oval_r <= hold_r; ol_r <= 1'b0; ost_r <= ST_LISTED;
            end
            first_r <= 1'b0;
            hold_r <= rdata;
            idx_r <= idx_r + CW'(1);
            state_r <= S_LIST_R;
          end
        end
        S_EMIT: begin
          if (out_free) begin
            oval_r <= pos_r; ol_r <= 1'b1;
            ost_r <= st_r;
            ocnt_r <= occ_r;
            state_r <= S_IDLE;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  // Output register only loads when free or being drained.
  property p_no_overrun;
    @(posedge clk) disable iff (!rst_n)
      (ov_r && !out_ready) |=> (ov_r && $stable(oval_r));
  endproperty
  a_no_overrun: assert property (p_no_overrun) else $error("result overwritten");

  a_occ_bound: assert property (@(posedge clk) disable iff (!rst_n)
    occ_r <= CW'(CAPACITY)) else $error("occupancy above capacity");

  a_busy_not_ready: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r != S_IDLE) |-> !in_ready) else $error("ready while busy");

  a_occ_step: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r != S_IDLE && !$past(state_r == S_IDLE)) |->
    (occ_r == $past(occ_r) || occ_r == $past(occ_r) + CW'(1) ||
     occ_r == $past(occ_r) - CW'(1))) else $error("occupancy jump");
endmodule
